>>> src/jdd_pkg.sv
// ----------------------------------------------------------------------------
// jdd_pkg: shared types and constants of the joystick deadzone block
// Field widths, configuration register indexes and the switch state word.
// ----------------------------------------------------------------------------
package jdd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NOW_W     = 32;
  localparam int RAD_W     = 13;
  localparam int DEB_W     = 16;
  localparam int RANGE_W   = 15;
  localparam int AXIS_W    = 16;
  localparam int FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_DEAD_RAD  = 3'd2,
    CFG_DEBOUNCE  = 3'd3,
    CFG_AXIS_RNG  = 3'd4,
    CFG_INVERT_X  = 3'd5,
    CFG_INVERT_Y  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic level_seen;
    logic accepted;
  } sw_state_t;

endpackage

>>> src/jdd_if.sv
// ----------------------------------------------------------------------------
// jdd_if: poll and result channels of the joystick deadzone block
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface jdd_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_x;
  logic [ADC_BITS-1:0] raw_y;
  logic                switch_low;
  logic [31:0]         now_ms;

  modport source (output valid, raw_x, raw_y, switch_low, now_ms, input ready);
  modport sink   (input valid, raw_x, raw_y, switch_low, now_ms, output ready);
endinterface

interface jdd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic               pressed;

  modport source (output valid, axis_x, axis_y, pressed, input ready);
  modport sink   (input valid, axis_x, axis_y, pressed, output ready);
endinterface

>>> src/joystick_deadzone_debounce_top.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_debounce_top: radial deadzone joystick with debounced key
// Each poll word gives one result word: X/Y scaled past a radial deadzone and
// normalized to the axis range, plus the debounced switch state.
// ----------------------------------------------------------------------------
// One poll is taken at a time. A poll inside the deadzone skips the square
// root and the divider. Outside it, the work is one square-root digit per
// cycle (ADC_BITS+17 steps) and, for each axis, one quotient bit per cycle of
// the restoring divider (ADC_BITS+15 steps). A finished result sits in the
// output register, so the next poll is taken while it waits to be read.
module joystick_deadzone_debounce_top #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  jdd_in_if.sink                        in_ch,
  jdd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [jdd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [jdd_pkg::CFG_W-1:0]     cfg_wdata
);
  import jdd_pkg::*;

  localparam int OFF_W    = ADC_BITS + 1;
  localparam int SQ_W     = 2 * ADC_BITS;
  localparam int D2_W     = 2 * ADC_BITS + 1;
  localparam int RR_W     = 2 * RAD_W;
  localparam int CMP_W    = (D2_W > RR_W) ? D2_W : RR_W;
  localparam int DQ_W     = ADC_BITS + 17;
  localparam int SQ_STEPS = ADC_BITS + 17;
  localparam int V_W      = 2 * (ADC_BITS + 1);
  localparam int SREM_W   = DQ_W + 2;
  localparam int RQ_W     = RAD_W + FRAC_BITS;
  localparam int EXT_W    = (DQ_W > RQ_W) ? DQ_W : RQ_W;
  localparam int P1_W     = ADC_BITS + DQ_W;
  localparam int H_W      = (P1_W + 1) / 2;
  localparam int NUM_W    = P1_W + RANGE_W;
  localparam int DEN_W    = DQ_W + ADC_BITS;
  localparam int QW       = ADC_BITS + RANGE_W;
  localparam int DREM_W   = DEN_W + 1;
  localparam int CNT_W    = $clog2(SQ_STEPS + 1);
  localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SUM, S_SQRT, S_AXIS, S_MLO, S_MHI,
    S_DINIT, S_DIV, S_RND, S_FIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [ADC_BITS-1:0] cx_r, cy_r;
  logic [RAD_W-1:0]    rad_r;
  logic [DEB_W-1:0]    deb_r;
  logic [RANGE_W-1:0]  range_r;
  logic                invx_r, invy_r;

  logic signed [OFF_W-1:0]  offx_r, offx_nxt, offy_r, offy_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [RR_W-1:0]          rr_r, rr_nxt;
  logic [V_W-1:0]           vsh_r, vsh_nxt;
  logic [DQ_W-1:0]          root_r, root_nxt;
  logic [SREM_W-1:0]        srem_r, srem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     axsel_r, axsel_nxt;
  logic                     neg_r, neg_nxt;
  logic [P1_W-1:0]          p1_r, p1_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic [DREM_W-1:0]        drem_r, drem_nxt;
  logic [QW-1:0]            nsh_r, nsh_nxt;
  logic [QW:0]              q_r, q_nxt;
  logic signed [AXIS_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [AXIS_W-1:0] out_ax_r, out_ax_nxt, out_ay_r, out_ay_nxt;
  logic                     out_pr_r, out_pr_nxt;

  logic                      accept;
  logic                      pressed;
  logic signed [2*OFF_W-1:0] px, py;
  logic [D2_W-1:0]           d2;
  logic [SREM_W-1:0]         srem_sh, trial;
  logic signed [OFF_W-1:0]   off_sel;
  logic [ADC_BITS-1:0]       cen_sel, mag, span;
  logic [EXT_W-1:0]          dq_ext, rq_ext, dmr_ext;
  logic [DREM_W-1:0]         dtry, den_ext;
  logic [RANGE_W-1:0]        qc;
  logic signed [AXIS_W-1:0]  qval;
  logic signed [AXIS_W-1:0]  out_abs_x, out_abs_y;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.axis_x  = out_ax_r;
  assign out_ch.axis_y  = out_ay_r;
  assign out_ch.pressed = out_pr_r;

  jdd_debounce #(
    .TIME_BITS (TIME_BITS)
  ) u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .level       (in_ch.switch_low),
    .now         (in_ch.now_ms[TIME_BITS-1:0]),
    .debounce_ms (deb_r),
    .pressed     (pressed)
  );

  always_comb begin
    state_nxt = state_r;
    offx_nxt  = offx_r;
    offy_nxt  = offy_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    rr_nxt    = rr_r;
    vsh_nxt   = vsh_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    cnt_nxt   = cnt_r;
    axsel_nxt = axsel_r;
    neg_nxt   = neg_r;
    p1_nxt    = p1_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    drem_nxt  = drem_r;
    nsh_nxt   = nsh_r;
    q_nxt     = q_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ax_nxt    = out_ax_r;
    out_ay_nxt    = out_ay_r;
    out_pr_nxt    = out_pr_r;

    px      = offx_r * offx_r;
    py      = offy_r * offy_r;
    d2      = D2_W'(sqx_r) + D2_W'(sqy_r);
    srem_sh = {srem_r[SREM_W-3:0], vsh_r[V_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    off_sel = axsel_r ? offy_r : offx_r;
    cen_sel = axsel_r ? cy_r : cx_r;
    mag     = off_sel[OFF_W-1] ? ADC_BITS'(-off_sel) : ADC_BITS'(off_sel);
    span    = off_sel[OFF_W-1] ? cen_sel : ADC_MAX - cen_sel;
    dq_ext  = EXT_W'(root_r);
    rq_ext  = EXT_W'({rad_r, {FRAC_BITS{1'b0}}});
    dmr_ext = dq_ext - rq_ext;
    den_ext = DREM_W'(den_r);
    dtry    = {drem_r[DREM_W-2:0], nsh_r[QW-1]};
    qc      = (q_r > (QW+1)'(range_r)) ? range_r : RANGE_W'(q_r);
    qval    = neg_r ? -$signed(AXIS_W'(qc)) : $signed(AXIS_W'(qc));

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          offx_nxt  = $signed({1'b0, in_ch.raw_x}) - $signed({1'b0, cx_r});
          offy_nxt  = $signed({1'b0, in_ch.raw_y}) - $signed({1'b0, cy_r});
          ax_nxt    = '0;
          ay_nxt    = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sqx_nxt   = SQ_W'(px);
        sqy_nxt   = SQ_W'(py);
        rr_nxt    = RR_W'(rad_r) * RR_W'(rad_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        vsh_nxt  = V_W'(d2);
        root_nxt = '0;
        srem_nxt = '0;
        cnt_nxt  = '0;
        if (CMP_W'(d2) > CMP_W'(rr_r)) begin
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SQRT: begin
        if (srem_sh >= trial) begin
          srem_nxt = srem_sh - trial;
          root_nxt = {root_r[DQ_W-2:0], 1'b1};
        end else begin
          srem_nxt = srem_sh;
          root_nxt = {root_r[DQ_W-2:0], 1'b0};
        end
        vsh_nxt = vsh_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          axsel_nxt = 1'b0;
          state_nxt = S_AXIS;
        end
      end
      S_AXIS: begin
        neg_nxt = off_sel[OFF_W-1];
        if (off_sel == '0) begin
          q_nxt     = '0;
          state_nxt = S_FIN;
        end else if (span == '0) begin
          q_nxt     = (QW+1)'(range_r);
          state_nxt = S_FIN;
        end else begin
          p1_nxt    = P1_W'(mag) * P1_W'(dmr_ext[DQ_W-1:0]);
          den_nxt   = DEN_W'(root_r) * DEN_W'(span);
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        num_nxt   = NUM_W'(p1_r[H_W-1:0]) * NUM_W'(range_r);
        state_nxt = S_MHI;
      end
      S_MHI: begin
        num_nxt   = num_r + ((NUM_W'(p1_r[P1_W-1:H_W]) * NUM_W'(range_r)) << H_W);
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        drem_nxt  = DREM_W'(num_r[NUM_W-1:QW]);
        nsh_nxt   = num_r[QW-1:0];
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dtry >= den_ext) begin
          drem_nxt = dtry - den_ext;
          q_nxt    = {q_r[QW-1:0], 1'b1};
        end else begin
          drem_nxt = dtry;
          q_nxt    = {q_r[QW-1:0], 1'b0};
        end
        nsh_nxt = nsh_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        if ({drem_r[DREM_W-2:0], 1'b0} >= den_ext) begin
          q_nxt = q_r + 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (axsel_r) begin
          ay_nxt    = qval;
          state_nxt = S_DONE;
        end else begin
          ax_nxt    = qval;
          axsel_nxt = 1'b1;
          state_nxt = S_AXIS;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ax_nxt    = invx_r ? -ax_r : ax_r;
          out_ay_nxt    = invy_r ? -ay_r : ay_r;
          out_pr_nxt    = pressed;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      axsel_r     <= 1'b0;
      cx_r        <= ADC_BITS'(2048);
      cy_r        <= ADC_BITS'(2048);
      rad_r       <= RAD_W'(100);
      deb_r       <= DEB_W'(20);
      range_r     <= RANGE_W'(1000);
      invx_r      <= 1'b0;
      invy_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      axsel_r     <= axsel_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_CENTER_X: cx_r    <= cfg_wdata[ADC_BITS-1:0];
          CFG_CENTER_Y: cy_r    <= cfg_wdata[ADC_BITS-1:0];
          CFG_DEAD_RAD: rad_r   <= cfg_wdata[RAD_W-1:0];
          CFG_DEBOUNCE: deb_r   <= cfg_wdata[DEB_W-1:0];
          CFG_AXIS_RNG: range_r <= cfg_wdata[RANGE_W-1:0];
          CFG_INVERT_X: invx_r  <= cfg_wdata[0];
          CFG_INVERT_Y: invy_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    offx_r   <= offx_nxt;
    offy_r   <= offy_nxt;
    sqx_r    <= sqx_nxt;
    sqy_r    <= sqy_nxt;
    rr_r     <= rr_nxt;
    vsh_r    <= vsh_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    neg_r    <= neg_nxt;
    p1_r     <= p1_nxt;
    den_r    <= den_nxt;
    num_r    <= num_nxt;
    drem_r   <= drem_nxt;
    nsh_r    <= nsh_nxt;
    q_r      <= q_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    out_ax_r <= out_ax_nxt;
    out_ay_r <= out_ay_nxt;
    out_pr_r <= out_pr_nxt;
  end

  assign out_abs_x = out_ax_r[AXIS_W-1] ? -out_ax_r : out_ax_r;
  assign out_abs_y = out_ay_r[AXIS_W-1] ? -out_ay_r : out_ay_r;

`ifndef SYNTHESIS
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (drem_r < den_ext))
    else $error("divider remainder not below divisor");
  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (srem_r <= SREM_W'({root_r, 1'b0})))
    else $error("square root remainder out of bound");
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($unsigned(out_abs_x) <= AXIS_W'(range_r)
                            && $unsigned(out_abs_y) <= AXIS_W'(range_r)))
    else $error("axis result exceeds axis range");
`endif

endmodule

>>> src/jdd_debounce.sv
// ----------------------------------------------------------------------------
// jdd_debounce: switch debouncer
// Any level change restarts the timer; the pressed state follows the level
// once it has been stable for the configured number of milliseconds.
// ----------------------------------------------------------------------------
module jdd_debounce #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      level,
  input  logic [TIME_BITS-1:0]      now,
  input  logic [jdd_pkg::DEB_W-1:0] debounce_ms,
  output logic                      pressed
);
  import jdd_pkg::*;

  sw_state_t            sw_r, sw_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    sw_nxt   = sw_r;
    last_nxt = last_r;
    elapsed  = '0;
    if (step) begin
      if (level != sw_r.level_seen) begin
        last_nxt = now;
      end
      sw_nxt.level_seen = level;
      elapsed = now - last_nxt;
      if (elapsed >= TIME_BITS'(debounce_ms)) begin
        sw_nxt.accepted = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= '0;
      last_r <= '0;
    end else begin
      sw_r   <= sw_nxt;
      last_r <= last_nxt;
    end
  end

  assign pressed = sw_r.accepted;

`ifndef SYNTHESIS
  a_zero_debounce_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (step && debounce_ms == '0) |=> (sw_r.accepted == $past(level)))
    else $error("zero debounce did not follow level");
  a_change_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step && level != sw_r.level_seen && debounce_ms != '0)
      |=> (sw_r.accepted == $past(sw_r.accepted)))
    else $error("level change updated pressed state early");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(sw_r) && $stable(last_r)))
    else $error("switch state moved without a poll");
`endif

endmodule

>>> tb/jdd_tb_if.sv
// ----------------------------------------------------------------------------
// jdd_tb_if: testbench-side note on the poll and result channels
// The channels are the block's own interfaces from src/jdd_if.sv; this file
// holds the testbench's poll and result word types used by the scoreboard.
// ----------------------------------------------------------------------------
package jdd_tb_pkg;

  typedef struct packed {
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic        switch_low;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic               pressed;
  } stick_t;

endpackage

>>> tb/joystick_deadzone_debounce_top_tb.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_debounce_top_tb: self-checking bench for the joystick block
// Drives directed and random polls across several register settings, predicts
// each result word with an independent deadzone/normalize/debounce model and
// compares every field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module joystick_deadzone_debounce_top_tb;
  import jdd_pkg::*;
  import jdd_tb_pkg::*;

  class stick_scoreboard;
    logic [11:0] cx = 2048, cy = 2048;
    logic [12:0] rad = 100;
    logic [15:0] deb = 20;
    logic [14:0] rng = 1000;
    bit inv_x, inv_y;
    bit lvl_seen, accepted;
    logic [31:0] t_change;
    stick_t pending[$];
    int errors, checked;

    function void reset_state();
      lvl_seen = 0;
      accepted = 0;
      t_change = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_CENTER_X: cx = v[11:0];
        CFG_CENTER_Y: cy = v[11:0];
        CFG_DEAD_RAD: rad = v[12:0];
        CFG_DEBOUNCE: deb = v;
        CFG_AXIS_RNG: rng = v[14:0];
        CFG_INVERT_X: inv_x = v[0];
        CFG_INVERT_Y: inv_y = v[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_q16(longint unsigned v);
      longint unsigned root, rem, trial, bits;
      root = 0;
      rem = 0;
      for (int k = 16; k >= -16; k--) begin
        bits = (k >= 0) ? ((v >> (2 * k)) & 3) : 0;
        rem = (rem << 2) | bits;
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function longint scale_axis(longint off, longint ctr, longint unsigned dq,
                                longint unsigned rq);
      longint unsigned mag, num, den, q, r;
      longint span;
      if (off == 0) return 0;
      mag = (off < 0) ? -off : off;
      span = (off < 0) ? ctr : 4095 - ctr;
      if (span <= 0) begin
        q = rng;
      end else begin
        num = mag * (dq - rq) * rng;
        den = dq * span;
        q = num / den;
        r = num % den;
        if (r >= den - r) q++;
        if (q > rng) q = rng;
      end
      return (off < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_poll(poll_t p);
      longint ox, oy, ax, ay;
      longint unsigned d2, dq;
      stick_t e;
      ox = longint'(p.raw_x) - longint'(cx);
      oy = longint'(p.raw_y) - longint'(cy);
      d2 = ox * ox + oy * oy;
      ax = 0;
      ay = 0;
      if (d2 > longint'(rad) * longint'(rad)) begin
        dq = root_q16(d2);
        ax = scale_axis(ox, cx, dq, longint'(rad) << 16);
        ay = scale_axis(oy, cy, dq, longint'(rad) << 16);
      end
      if (inv_x) ax = -ax;
      if (inv_y) ay = -ay;
      if (p.switch_low != lvl_seen) begin
        lvl_seen = p.switch_low;
        t_change = p.now_ms;
      end
      if (32'(p.now_ms - t_change) >= deb) accepted = lvl_seen;
      e.axis_x = ax[15:0];
      e.axis_y = ay[15:0];
      e.pressed = accepted;
      pending.push_back(e);
    endfunction

    function void check_word(stick_t got);
      stick_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected x=%0d y=%0d p=%0b, got x=%0d y=%0d p=%0b",
                   e.axis_x, e.axis_y, e.pressed, got.axis_x, got.axis_y, got.pressed);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  jdd_in_if #(.ADC_BITS(12)) in_ch ();
  jdd_out_if out_ch ();

  stick_scoreboard sb = new();
  int idle_pct = 24;
  int stall_cnt = 0;
  int watchdog = 0;
  int sent = 0;
  logic [31:0] clock_ms = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.raw_x = 0;
    in_ch.raw_y = 0;
    in_ch.switch_low = 0;
    in_ch.now_ms = 0;
    out_ch.ready = 0;
  end

  joystick_deadzone_debounce_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.axis_x, out_ch.axis_y, out_ch.pressed});
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_poll(
      {in_ch.raw_x, in_ch.raw_y, in_ch.switch_low, in_ch.now_ms});
  end

  always @(posedge clk) begin
    if (stall_cnt > 0) stall_cnt <= stall_cnt - 1;
    out_ch.ready <= rst_n && stall_cnt <= 1 &&
                    ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog > 20000) begin
      $display("timeout waiting for a handshake");
      $display("[joystick_deadzone_debounce_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_poll(logic [11:0] x, logic [11:0] y, bit sw, logic [31:0] t);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.raw_x <= x;
    in_ch.raw_y <= y;
    in_ch.switch_low <= sw;
    in_ch.now_ms <= t;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 0;
    sent++;
  endtask

  task automatic random_polls(int n);
    bit sw;
    logic [11:0] x, y;
    sw = 0;
    for (int i = 0; i < n; i++) begin
      clock_ms += $urandom_range(3) == 0 ? $urandom : $urandom_range(30);
      if ($urandom_range(5) == 0) sw = !sw;
      case ($urandom_range(3))
        0: begin x = $urandom; y = $urandom; end
        1: begin x = sb.cx + $urandom_range(300) - 150;
                 y = sb.cy + $urandom_range(300) - 150; end
        2: begin x = $urandom_range(1) ? 12'hfff : 0; y = $urandom; end
        default: begin x = $urandom; y = $urandom_range(1) ? 12'hfff : 0; end
      endcase
      send_poll(x, y, sw, clock_ms);
    end
  endtask

  task automatic config_all(logic [11:0] cx, logic [11:0] cy, logic [12:0] r,
                            logic [15:0] d, logic [14:0] a, bit ix, bit iy);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_DEAD_RAD, r);
    write_reg(CFG_DEBOUNCE, d);
    write_reg(CFG_AXIS_RNG, a);
    write_reg(CFG_INVERT_X, ix);
    write_reg(CFG_INVERT_Y, iy);
  endtask

  initial begin
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: centers, corners, deadzone edge and switch timing at reset values.
    send_poll(2048, 2048, 0, 0);
    send_poll(4095, 4095, 1, 5);
    send_poll(0, 0, 1, 24);
    send_poll(0, 4095, 1, 25);
    send_poll(2148, 2048, 0, 26);
    send_poll(2149, 2048, 0, 30);
    send_poll(2048, 1948, 0, 46);
    send_poll(4095, 2048, 0, 32'hffff_fff0);
    send_poll(2048, 0, 0, 32'h0000_0004);
    drain();

    // Empty spans, zero range, zero radius, zero debounce.
    config_all(12'hfff, 0, 0, 0, 1, 1, 1);
    send_poll(4095, 0, 1, 100);
    send_poll(0, 4095, 0, 100);
    send_poll(12, 34, 1, 101);
    send_poll(4095, 0, 0, 101);
    drain();
    write_reg(CFG_AXIS_RNG, 0);
    send_poll(100, 3000, 1, 200);
    drain();
    config_all(0, 12'hfff, 13'd4096, 16'hffff, 15'h7fff, 0, 1);
    send_poll(4095, 0, 1, 300);
    send_poll(0, 4095, 1, 300 + 65534);
    send_poll(2000, 3000, 1, 300 + 65535);
    drain();

    config_all(2048, 2048, 100, 20, 1000, 0, 0);
    random_polls(300);
    drain();
    config_all($urandom, $urandom, $urandom_range(400), $urandom_range(50),
               $urandom_range(32767, 1), 1, 0);
    random_polls(300);

    // Hold the receiver off so the block backs up its input.
    stall_cnt = 400;
    random_polls(4);
    drain();

    config_all($urandom, $urandom, $urandom_range(4096), $urandom, 15'h7fff, 0, 1);
    idle_pct = 0;
    random_polls(200);
    idle_pct = 24;
    random_polls(100);
    drain();
    config_all(1, 4094, 0, 0, 1, 1, 1);
    random_polls(300);
    drain();

    $display("Covered %0d polls over six register settings, including empty spans,",
             sent);
    $display("zero range and radius, time wraparound and long receiver stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[joystick_deadzone_debounce_top] OK");
    else
      $display("[joystick_deadzone_debounce_top] ERROR");
    $finish;
  end
endmodule

>>> files.f
src/jdd_pkg.sv
src/jdd_if.sv
src/jdd_debounce.sv
src/joystick_deadzone_debounce_top.sv
tb/jdd_tb_if.sv
tb/joystick_deadzone_debounce_top_tb.sv
